### src/fwch_pkg.sv
// package: constants, hop tables and result type of the frame whitening channel hopper
package fwch_pkg;

  localparam int FrameSymbolsDef = 64;
  localparam int ChannelCount    = 19;
  localparam int HopTableCount   = 4;

  localparam logic [4:0] LastHopPos   = 5'(ChannelCount - 1);
  localparam logic [6:0] SeedBase     = 7'h60;
  localparam logic [5:0] HeaderLenRst = 6'd16;

  localparam logic [1:0] RegHopSequence  = 2'd0;
  localparam logic [1:0] RegHeaderLength = 2'd1;

  localparam logic [4:0] HopTable [HopTableCount][ChannelCount] = '{
    '{5'd3, 5'd14, 5'd5, 5'd6, 5'd9, 5'd2, 5'd12, 5'd8, 5'd15, 5'd4,
      5'd11, 5'd13, 5'd17, 5'd10, 5'd1, 5'd7, 5'd0, 5'd18, 5'd16},
    '{5'd10, 5'd3, 5'd15, 5'd5, 5'd0, 5'd17, 5'd13, 5'd6, 5'd11, 5'd4,
      5'd8, 5'd18, 5'd9, 5'd14, 5'd1, 5'd12, 5'd7, 5'd16, 5'd2},
    '{5'd14, 5'd5, 5'd11, 5'd3, 5'd8, 5'd2, 5'd18, 5'd4, 5'd10, 5'd13,
      5'd9, 5'd1, 5'd16, 5'd17, 5'd0, 5'd6, 5'd15, 5'd12, 5'd7},
    '{5'd7, 5'd0, 5'd11, 5'd18, 5'd4, 5'd2, 5'd13, 5'd5, 5'd10, 5'd17,
      5'd3, 5'd9, 5'd16, 5'd14, 5'd8, 5'd12, 5'd1, 5'd6, 5'd15}
  };

  typedef struct packed {
    logic [5:0]  whitened_symbol;
    logic [5:0]  frame_index;
    logic [5:0]  frame_position;
    logic [4:0]  frame_channel;
    logic        new_frame;
    logic [11:0] total_symbols;
    logic        end_of_packet;
  } result_t;

  function automatic logic [4:0] next_hop_pos(input logic [4:0] pos);
    next_hop_pos = (pos >= LastHopPos) ? 5'd0 : pos + 5'd1;
  endfunction

endpackage

### src/frame_whitening_channel_hopper_core.sv
// frame whitening and channel hopping core: lfsr whitening, frame slots and hop channels
// the result of an accepted input transaction is registered and valid in the next cycle
// throughput: one symbol per cycle while results are taken; state updates in a single pass at input acceptance
// input is accepted while the result register is empty or its result is taken that cycle
// reset: hop position at last table entry, lfsr, counters and channel cleared,
// hop table 0, header length 16, no result pending
module frame_whitening_channel_hopper_core
  import fwch_pkg::*;
#(
  parameter int FrameSymbols = FrameSymbolsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  symbol_i,
  input  logic        first_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  whitened_symbol_o,
  output logic [5:0]  frame_index_o,
  output logic [5:0]  frame_position_o,
  output logic [4:0]  frame_channel_o,
  output logic        new_frame_o,
  output logic [11:0] total_symbols_o,
  output logic        end_of_packet_o
);

  logic [1:0] hop_seq_q;
  logic [5:0] hdr_len_q;
  logic [4:0] hop_pos_q, hop_pos_d;
  logic [6:0] lfsr_q, lfsr_d;
  logic [5:0] slot_q, slot_d;
  logic [5:0] frame_q, frame_d;
  logic [4:0] chan_q, chan_d;
  logic       out_valid_q;
  result_t    res_q, res_d;
  logic       accept;

  logic [4:0] pos_a;
  logic [4:0] chan_a;
  logic [6:0] lfsr_a;
  logic [5:0] slot_a;
  logic [5:0] frame_a;
  logic       opened;
  logic [5:0] bits;
  logic [6:0] lfsr_s;
  logic [11:0] total;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // packet start: first hop seeds the lfsr
    pos_a   = hop_pos_q;
    chan_a  = chan_q;
    lfsr_a  = lfsr_q;
    slot_a  = slot_q;
    frame_a = frame_q;
    if (first_i) begin
      pos_a   = next_hop_pos(hop_pos_q);
      chan_a  = HopTable[hop_seq_q][pos_a];
      lfsr_a  = SeedBase | {2'b00, chan_a};
      slot_a  = hdr_len_q;
      frame_a = '0;
    end

    // frame boundary: next hop goes to the frame
    opened    = (slot_a == '0) || ({1'b0, slot_a} >= 7'(FrameSymbols));
    hop_pos_d = pos_a;
    chan_d    = chan_a;
    frame_d   = frame_a;
    if (opened) begin
      slot_a    = '0;
      frame_d   = frame_a + 6'd1;
      hop_pos_d = next_hop_pos(pos_a);
      chan_d    = HopTable[hop_seq_q][hop_pos_d];
    end

    lfsr_s = lfsr_a;
    bits   = '0;
    for (int i = 0; i < 6; i++) begin
      bits[5-i] = lfsr_s[6];
      lfsr_s    = {lfsr_s[5:0], lfsr_s[6] ^ lfsr_s[3]};
    end
    lfsr_d = lfsr_s;

    total  = 12'({6'd0, slot_a} + 12'd1 + 12'(12'(frame_d) * 12'(FrameSymbols)));
    slot_d = slot_a + 6'd1;

    res_d.whitened_symbol = symbol_i ^ bits;
    res_d.frame_index     = frame_d;
    res_d.frame_position  = slot_a;
    res_d.frame_channel   = chan_d;
    res_d.new_frame       = opened;
    res_d.total_symbols   = last_i ? total : 12'd0;
    res_d.end_of_packet   = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_seq_q   <= '0;
      hdr_len_q   <= HeaderLenRst;
      hop_pos_q   <= LastHopPos;
      lfsr_q      <= '0;
      slot_q      <= '0;
      frame_q     <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegHopSequence) begin
          hop_seq_q <= cfg_data_i[1:0];
          hop_pos_q <= LastHopPos;
        end else if (cfg_index_i == RegHeaderLength) begin
          hdr_len_q <= cfg_data_i;
        end
      end
      if (accept) begin
        hop_pos_q <= hop_pos_d;
        lfsr_q    <= lfsr_d;
        slot_q    <= slot_d;
        frame_q   <= frame_d;
        chan_q    <= chan_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign whitened_symbol_o = res_q.whitened_symbol;
  assign frame_index_o     = res_q.frame_index;
  assign frame_position_o  = res_q.frame_position;
  assign frame_channel_o   = res_q.frame_channel;
  assign new_frame_o       = res_q.new_frame;
  assign total_symbols_o   = res_q.total_symbols;
  assign end_of_packet_o   = res_q.end_of_packet;

endmodule
